// ===== rtl/core/tlv_metric_packet_parser_assert.svh =====
// Assertion macros for the metric packet parser
`ifndef TLV_METRIC_PACKET_PARSER_ASSERT_SVH
`define TLV_METRIC_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication checked every clock edge outside reset
`define TMP_ASSERT_IMP(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked outside reset
`define TMP_ASSERT_NXT(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/core/tmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and constants of the metric packet parser.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_OK    = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_TRUNC     = 4'd1;
  localparam logic [3:0] ERR_BAD_LEN   = 4'd2;
  localparam logic [3:0] ERR_BAD_STR   = 4'd3;
  localparam logic [3:0] ERR_INT_SIZE  = 4'd4;
  localparam logic [3:0] ERR_COUNT     = 4'd5;
  localparam logic [3:0] ERR_TOO_MANY  = 4'd6;
  localparam logic [3:0] ERR_BAD_TYPE  = 4'd7;
  localparam logic [3:0] ERR_UNKNOWN   = 4'd8;
  localparam logic [3:0] ERR_UNSUPP    = 4'd9;

  localparam logic [15:0] T_HOST       = 16'h0000;
  localparam logic [15:0] T_TIME       = 16'h0001;
  localparam logic [15:0] T_PLUGIN     = 16'h0002;
  localparam logic [15:0] T_PLUGIN_INST = 16'h0003;
  localparam logic [15:0] T_TYPE       = 16'h0004;
  localparam logic [15:0] T_TYPE_INST  = 16'h0005;
  localparam logic [15:0] T_VALUES     = 16'h0006;
  localparam logic [15:0] T_INTERVAL   = 16'h0007;
  localparam logic [15:0] T_TIME_HR    = 16'h0008;
  localparam logic [15:0] T_INTERVAL_HR = 16'h0009;
  localparam logic [15:0] T_SIGN       = 16'h0200;
  localparam logic [15:0] T_ENCR       = 16'h0210;

  localparam logic [1:0] VT_GAUGE = 2'd1;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  ident_part;
    logic [63:0] data;
    logic [1:0]  value_type;
    logic [5:0]  value_index;
    logic [63:0] time_fx;
    logic [63:0] interval_fx;
    logic [3:0]  error_code;
    logic        last;
  } result_t;

  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] secs_to_fx(input logic [63:0] s);
    logic [33:0] w;
    w = (s[63:34] != '0) ? '1 : s[33:0];
    return {w, 30'd0};
  endfunction

endpackage

// ===== rtl/core/tmp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tmp_ram #(
  parameter int Width = 2,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/tmp_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_outq
// Four-entry result queue between the parser core and the output channel.
// ----------------------------------------------------------------------------
module tmp_outq
  import tmp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push0_i,
  input  logic    push1_i,
  input  result_t res0_i,
  input  result_t res1_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t res_o,
  input  logic    ready_i
);

  result_t     buf_q [4];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  logic        pop;
  logic [1:0]  npush;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 3'd0);
  assign res_o   = buf_q[rp_q];
  assign npush   = {1'b0, push0_i} + {1'b0, push1_i};
  // room for two more results, not counting this cycle's pop
  assign room_o  = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + npush;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, npush} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      buf_q[wp_q] <= res0_i;
    end
    if (push1_i) begin
      buf_q[push0_i ? wp_q + 2'd1 : wp_q] <= res1_i;
    end
  end

endmodule

// ===== rtl/core/tmp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmp_core
// Byte-serial parse state machine; value types live in a small RAM.
// ----------------------------------------------------------------------------
module tmp_core
  import tmp_pkg::*;
#(
  parameter int NameLen   = 64,
  parameter int MaxValues = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [7:0]  byte_i,
  input  logic        eop_i,
  output logic        push0_o,
  output logic        push1_o,
  output result_t     res0_o,
  output result_t     res1_o
);

  localparam int AW = (MaxValues > 1) ? $clog2(MaxValues) : 1;

  localparam logic [2:0] PH_HDR    = 3'd0;
  localparam logic [2:0] PH_IDENT  = 3'd1;
  localparam logic [2:0] PH_TIME   = 3'd2;
  localparam logic [2:0] PH_VCOUNT = 3'd3;
  localparam logic [2:0] PH_VTYPES = 3'd4;
  localparam logic [2:0] PH_VVALS  = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] ptype_q, ptype_d;
  logic [15:0] left_q, left_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [15:0] vcnt_q, vcnt_d;
  logic [15:0] item_q, item_d;
  logic [63:0] asm_q, asm_d;
  logic [63:0] time_q, time_d;
  logic [63:0] intv_q, intv_d;
  logic        nul_q, nul_d;
  logic        errh_q, errh_d;

  // type RAM: read address runs one item ahead in value phase
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]    wdata, rdata;

  tmp_ram #(.Width(2), .Depth(MaxValues)) u_types (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  function automatic logic [2:0] ident_idx(input logic [15:0] t);
    case (t)
      T_HOST:        return 3'd0;
      T_PLUGIN:      return 3'd1;
      T_PLUGIN_INST: return 3'd2;
      T_TYPE:        return 3'd3;
      default:       return 3'd4;
    endcase
  endfunction

  function automatic logic is_ident(input logic [15:0] t);
    return (t == T_HOST) || (t == T_PLUGIN) || (t == T_PLUGIN_INST) ||
           (t == T_TYPE) || (t == T_TYPE_INST);
  endfunction

  logic [15:0] t_w, len_w, left_dec, left_new;
  logic [31:0] hdr_w;
  logic [15:0] n_w;
  logic [19:0] n9;
  logic        e0, e1;
  result_t     r0, r1, blank;
  logic        fos;     // fail-or-skip request
  logic [3:0]  fos_code;

  assign left_dec = left_q - 16'd1;
  assign hdr_w    = {asm_q[23:0], byte_i};
  assign t_w      = hdr_w[31:16];
  assign len_w    = hdr_w[15:0];
  assign left_new = len_w - 16'd4;
  assign n_w      = {asm_q[7:0], byte_i};
  assign n9       = {n_w, 3'd0} + {4'd0, n_w};

  always_comb begin
    blank = '0;
    phase_d = phase_q; ptype_d = ptype_q; left_d = left_q; hcnt_d = hcnt_q;
    vcnt_d = vcnt_q; item_d = item_q; asm_d = asm_q; time_d = time_q;
    intv_d = intv_q; nul_d = nul_q; errh_d = errh_q;
    e0 = 1'b0; e1 = 1'b0; r0 = blank; r1 = blank;
    fos = 1'b0; fos_code = ERR_NONE;
    we = 1'b0; waddr = item_q[AW-1:0]; wdata = byte_i[1:0];
    raddr = item_q[AW-1:0];

    if (acc_i && !errh_q) begin
      if (phase_q == PH_HDR) begin
        asm_d  = {32'd0, hdr_w};
        hcnt_d = hcnt_q + 2'd1;
        if (hcnt_q == 2'd3) begin
          hcnt_d = '0;
          asm_d  = '0;
          if (len_w < 16'd5) begin
            e0 = 1'b1; r0.kind = KIND_ERR; r0.error_code = ERR_BAD_LEN;
            errh_d = 1'b1;
          end else begin
            ptype_d = t_w;
            left_d  = left_new;
            nul_d   = 1'b0;
            item_d  = '0;
            if (is_ident(t_w)) begin
              if ({16'd0, left_new} > 32'(NameLen)) begin
                fos = 1'b1; fos_code = ERR_BAD_STR;
              end else phase_d = PH_IDENT;
            end else if (t_w == T_TIME || t_w == T_INTERVAL ||
                         t_w == T_TIME_HR || t_w == T_INTERVAL_HR) begin
              if (left_new != 16'd8) begin
                fos = 1'b1; fos_code = ERR_INT_SIZE;
              end else phase_d = PH_TIME;
            end else if (t_w == T_VALUES) begin
              if (left_new < 16'd2) begin
                fos = 1'b1; fos_code = ERR_COUNT;
              end else phase_d = PH_VCOUNT;
            end else if (t_w == T_SIGN || t_w == T_ENCR) begin
              fos = 1'b1; fos_code = ERR_UNSUPP;
            end else begin
              fos = 1'b1; fos_code = ERR_UNKNOWN;
            end
          end
        end
      end else if (left_q == 16'd0) begin
        phase_d = PH_HDR;
      end else begin
        left_d = left_dec;
        case (phase_q)
          PH_IDENT: begin
            if (!nul_q) begin
              e0 = 1'b1; r0.kind = KIND_CHAR; r0.ident_part = ident_idx(ptype_q);
              r0.data = {56'd0, byte_i};
              if (byte_i == 8'd0) nul_d = 1'b1;
            end
            if (left_dec == 16'd0) begin
              if (byte_i != 8'd0) begin
                if (e0) begin
                  e1 = 1'b1; r1.kind = KIND_ERR; r1.error_code = ERR_BAD_STR;
                end else begin
                  e0 = 1'b1; r0.kind = KIND_ERR; r0.error_code = ERR_BAD_STR;
                end
                errh_d = 1'b1;
              end else phase_d = PH_HDR;
            end
          end
          PH_TIME: begin
            asm_d = {asm_q[55:0], byte_i};
            if (left_dec == 16'd0) begin
              case (ptype_q)
                T_TIME:     time_d = secs_to_fx(asm_d);
                T_INTERVAL: intv_d = secs_to_fx(asm_d);
                T_TIME_HR:  time_d = asm_d;
                default:    intv_d = asm_d;
              endcase
              asm_d = '0;
              phase_d = PH_HDR;
            end
          end
          PH_VCOUNT: begin
            asm_d  = {48'd0, n_w};
            hcnt_d = hcnt_q + 2'd1;
            if (hcnt_q == 2'd1) begin
              hcnt_d = '0;
              asm_d  = '0;
              if (n9 != {4'd0, left_dec}) begin
                fos = 1'b1; fos_code = ERR_COUNT;
              end else if ({16'd0, n_w} > 32'(MaxValues)) begin
                fos = 1'b1; fos_code = ERR_TOO_MANY;
              end else if (n_w == 16'd0) begin
                phase_d = PH_HDR;
              end else begin
                vcnt_d = n_w;
                item_d = '0;
                phase_d = PH_VTYPES;
              end
            end
          end
          PH_VTYPES: begin
            if (byte_i > 8'd3) begin
              fos = 1'b1; fos_code = ERR_BAD_TYPE;
            end else begin
              we = 1'b1;
              item_d = item_q + 16'd1;
              if (item_d >= vcnt_q) begin
                item_d = '0;
                asm_d  = '0;
                phase_d = PH_VVALS;
              end
            end
            raddr = '0;  // prefetch first type
          end
          PH_VVALS: begin
            asm_d = {asm_q[55:0], byte_i};
            if (left_dec[2:0] == 3'd0) begin
              e0 = 1'b1; r0.kind = KIND_VALUE;
              r0.value_type = rdata;
              r0.data = (rdata == VT_GAUGE) ? swap64(asm_d) : asm_d;
              r0.value_index = item_q[5:0];
              r0.time_fx = time_q; r0.interval_fx = intv_q;
              item_d = item_q + 16'd1;
              asm_d = '0;
              if (left_dec == 16'd0) begin
                item_d = '0;
                phase_d = PH_HDR;
              end
            end
            // point the read at the value in flight after this byte
            raddr = item_d[AW-1:0];
          end
          default: begin
            if (left_dec == 16'd0) begin
              e0 = 1'b1; r0.kind = KIND_ERR; r0.error_code = asm_q[3:0];
              errh_d = 1'b1;
            end
          end
        endcase
      end

      if (fos) begin
        if (left_d == 16'd0) begin
          e0 = 1'b1; r0 = blank; r0.kind = KIND_ERR; r0.error_code = fos_code;
          errh_d = 1'b1;
        end else begin
          asm_d = {60'd0, fos_code};
          phase_d = PH_SKIP;
        end
      end

      if (eop_i && !errh_d) begin
        if (phase_d == PH_HDR && hcnt_d == 2'd0) begin
          if (e0) begin e1 = 1'b1; r1 = blank; r1.kind = KIND_OK; end
          else begin e0 = 1'b1; r0 = blank; r0.kind = KIND_OK; end
        end else begin
          if (e0) begin e1 = 1'b1; r1 = blank; r1.kind = KIND_ERR; r1.error_code = ERR_TRUNC; end
          else begin e0 = 1'b1; r0 = blank; r0.kind = KIND_ERR; r0.error_code = ERR_TRUNC; end
        end
      end
    end

    if (acc_i && eop_i) begin
      phase_d = PH_HDR; ptype_d = '0; left_d = '0; hcnt_d = '0; vcnt_d = '0;
      item_d = '0; asm_d = '0; time_d = '0; intv_d = '0; nul_d = 1'b0;
      errh_d = 1'b0;
    end

    r0.last = !e1;
    r1.last = 1'b1;
  end

  assign push0_o = e0;
  assign push1_o = e1;
  assign res0_o  = r0;
  assign res1_o  = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; ptype_q <= '0; left_q <= '0; hcnt_q <= '0;
      vcnt_q <= '0; item_q <= '0; asm_q <= '0; time_q <= '0; intv_q <= '0;
      nul_q <= 1'b0; errh_q <= 1'b0;
    end else begin
      phase_q <= phase_d; ptype_q <= ptype_d; left_q <= left_d; hcnt_q <= hcnt_d;
      vcnt_q <= vcnt_d; item_q <= item_d; asm_q <= asm_d; time_q <= time_d;
      intv_q <= intv_d; nul_q <= nul_d; errh_q <= errh_d;
    end
  end

endmodule

// ===== rtl/core/tlv_metric_packet_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metric packet parser, one packet byte per input word.
// Input channel: in_valid_i/in_ready_o carry byte_in_i and end_of_packet_i.
// Output channel: out_valid_o/out_ready_i carry one result word per handshake
// (identifier character, value, packet ok or packet error); last_o marks the
// final result caused by a byte, and a byte causes zero, one or two results.
// Results of a byte are queued at the edge that accepts it and reach the
// output from the queue. A byte is taken every cycle while the four-entry
// result queue has room for two more words; the queue is the only limit.
// Value types are held in a RAM of MAX_VALUES entries with a registered read;
// the read address runs one value ahead, so no interlock is needed.
// Reset returns the parser to the first header byte with an empty queue and
// zero time and interval. A stalled receiver fills the queue and then drops
// in_ready_o until space frees up; nothing is lost.
// After an error, bytes are swallowed until end_of_packet.
// ----------------------------------------------------------------------------
module tlv_metric_packet_parser
  import tmp_pkg::*;
#(
  parameter int NAME_LEN   = 64,
  parameter int MAX_VALUES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  ident_part_o,
  output logic [63:0] data_out_o,
  output logic [1:0]  value_type_o,
  output logic [5:0]  value_index_o,
  output logic [63:0] time_fx_o,
  output logic [63:0] interval_fx_o,
  output logic [3:0]  error_code_o,
  output logic        last_o
);

  `include "tlv_metric_packet_parser_assert.svh"

  logic    acc, push0, push1, room;
  result_t r0, r1, res;

  assign in_ready_o = room;
  assign acc        = in_valid_i && in_ready_o;

  tmp_core #(.NameLen(NAME_LEN), .MaxValues(MAX_VALUES)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .byte_i  (byte_in_i),
    .eop_i   (end_of_packet_i),
    .push0_o (push0),
    .push1_o (push1),
    .res0_o  (r0),
    .res1_o  (r1)
  );

  tmp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .res0_i  (r0),
    .res1_i  (r1),
    .room_o  (room),
    .valid_o (out_valid_o),
    .res_o   (res),
    .ready_i (out_ready_i)
  );

  assign kind_o        = res.kind;
  assign ident_part_o  = res.ident_part;
  assign data_out_o    = res.data;
  assign value_type_o  = res.value_type;
  assign value_index_o = res.value_index;
  assign time_fx_o     = res.time_fx;
  assign interval_fx_o = res.interval_fx;
  assign error_code_o  = res.error_code;
  assign last_o        = res.last;

  `TMP_ASSERT_IMP(a_push_order, clk_i, rst_ni, push1, push0, "second result without first")
  `TMP_ASSERT_IMP(a_push_acc, clk_i, rst_ni, push0, acc, "result without accepted byte")
  `TMP_ASSERT_NXT(a_push_visible, clk_i, rst_ni, push0, out_valid_o, "queued result not shown")
  `TMP_ASSERT_IMP(a_err_code, clk_i, rst_ni, out_valid_o && kind_o != KIND_ERR,
                  error_code_o == ERR_NONE, "error code on non-error result")

endmodule
